>>> rtl/core/assert_macros.svh
// Assertion macros shared by the date-time parser RTL.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/idtp_pkg.sv
// Shared types, character codes and helpers for the date-time parser.
// Depends on nothing; used by idtp_fsm and iso_date_time_parser_top.
package idtp_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UP_T  = 8'h54;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	localparam logic [19:0] SECS_PER_HOUR = 20'd3600;
	localparam logic [19:0] SECS_PER_MIN  = 20'd60;

	localparam int TDATA_W = 72;
	localparam int TUSER_W = 4;

	// Parser position, one-hot; the order matters, as a step forward is a left shift.
	typedef enum logic [27:0] {
		PH_LEAD  = 28'd1 << 0,
		PH_Y1    = 28'd1 << 1,
		PH_Y2    = 28'd1 << 2,
		PH_Y3    = 28'd1 << 3,
		PH_DASH1 = 28'd1 << 4,
		PH_MO0   = 28'd1 << 5,
		PH_MO1   = 28'd1 << 6,
		PH_DASH2 = 28'd1 << 7,
		PH_DA0   = 28'd1 << 8,
		PH_DA1   = 28'd1 << 9,
		PH_DATE  = 28'd1 << 10,
		PH_H0    = 28'd1 << 11,
		PH_H1    = 28'd1 << 12,
		PH_C1    = 28'd1 << 13,
		PH_MI0   = 28'd1 << 14,
		PH_MI1   = 28'd1 << 15,
		PH_C2    = 28'd1 << 16,
		PH_S0    = 28'd1 << 17,
		PH_S1    = 28'd1 << 18,
		PH_SEC   = 28'd1 << 19,
		PH_FRAC  = 28'd1 << 20,
		PH_ZSIGN = 28'd1 << 21,
		PH_ZH1   = 28'd1 << 22,
		PH_ZHH   = 28'd1 << 23,
		PH_ZMF   = 28'd1 << 24,
		PH_ZMS   = 28'd1 << 25,
		PH_ZEND  = 28'd1 << 26,
		PH_ZZ    = 28'd1 << 27
	} idtp_phase_t;

	typedef struct packed {
		logic               valid_res;
		logic [13:0]        year;
		logic [6:0]         month;
		logic [6:0]         day;
		logic               has_time;
		logic [6:0]         hour;
		logic [6:0]         minute;
		logic [6:0]         second;
		logic               has_zone;
		logic               zone_was_z;
		logic signed [19:0] offset_seconds;
	} idtp_res_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Decimal shift-in of one digit, wrapping at 14 bits.
	function automatic logic [13:0] acc10(input logic [13:0] a, input logic [3:0] d);
		return (a << 3) + (a << 1) + {10'd0, d};
	endfunction

endpackage

>>> rtl/core/idtp_fsm.sv
// Byte-wise parser state and the result assembled on the final byte.
// Depends on idtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module idtp_fsm
	import idtp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  logic [7:0] ch,
	input  logic      last,
	output idtp_res_t res
);

	idtp_phase_t phase_q, phase_d;
	logic [13:0] year_q, year_d;
	logic [6:0]  month_q, month_d, day_q, day_d;
	logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
	logic [6:0]  zh_q, zh_d, zm_q, zm_d;
	logic        zneg_q, zneg_d, zseen_q, zseen_d, zz_q, zz_d;
	logic        failed_q, failed_d, timed_q, timed_d, trail_q, trail_d;

	logic        dg, zs, ok, signed_zone;
	logic [3:0]  d;
	logic [19:0] mag;

	assign dg = is_dig(ch);
	assign d  = dg ? ch[3:0] : 4'd0;

	always_comb begin
		phase_d  = phase_q;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		zh_d     = zh_q;
		zm_d     = zm_q;
		zneg_d   = zneg_q;
		zseen_d  = zseen_q;
		zz_d     = zz_q;
		failed_d = failed_q;
		timed_d  = timed_q;
		trail_d  = trail_q;
		zs       = 1'b0;
		if (!failed_q) begin
			if (is_ws(ch)) begin
				if (phase_q != PH_LEAD) trail_d = 1'b1;
			end else if (trail_q) begin
				failed_d = 1'b1;
			end else begin
				unique case (phase_q) inside
					PH_LEAD, PH_Y1, PH_Y2, PH_Y3: begin
						if (dg) begin
							year_d  = acc10(year_q, d);
							phase_d = idtp_phase_t'(phase_q << 1);
						end else failed_d = 1'b1;
					end
					PH_DASH1, PH_DASH2: begin
						if (ch == CH_DASH) phase_d = idtp_phase_t'(phase_q << 1);
						else failed_d = 1'b1;
					end
					PH_C1, PH_C2: begin
						if (ch == CH_COLON) phase_d = idtp_phase_t'(phase_q << 1);
						else failed_d = 1'b1;
					end
					PH_MO0, PH_MO1: begin
						if (dg) begin
							month_d = 7'(acc10({7'd0, month_q}, d));
							phase_d = idtp_phase_t'(phase_q << 1);
						end else failed_d = 1'b1;
					end
					PH_DA0, PH_DA1: begin
						if (dg) begin
							day_d   = 7'(acc10({7'd0, day_q}, d));
							phase_d = idtp_phase_t'(phase_q << 1);
						end else failed_d = 1'b1;
					end
					PH_DATE: begin
						if (ch == CH_UP_T) phase_d = PH_H0;
						else zs = 1'b1;
					end
					PH_H0, PH_H1: begin
						if (dg) begin
							hour_d  = 7'(acc10({7'd0, hour_q}, d));
							phase_d = idtp_phase_t'(phase_q << 1);
						end else failed_d = 1'b1;
					end
					PH_MI0, PH_MI1: begin
						if (dg) begin
							minute_d = 7'(acc10({7'd0, minute_q}, d));
							phase_d  = idtp_phase_t'(phase_q << 1);
						end else failed_d = 1'b1;
					end
					PH_S0, PH_S1: begin
						if (dg) begin
							second_d = 7'(acc10({7'd0, second_q}, d));
							phase_d  = idtp_phase_t'(phase_q << 1);
							if (phase_q == PH_S1) timed_d = 1'b1;
						end else failed_d = 1'b1;
					end
					PH_SEC: begin
						if (ch == CH_DOT) phase_d = PH_FRAC;
						else zs = 1'b1;
					end
					PH_FRAC: begin
						if (!dg) zs = 1'b1;
					end
					PH_ZSIGN: begin
						if (dg) begin
							zh_d    = {3'd0, d};
							phase_d = PH_ZH1;
						end else failed_d = 1'b1;
					end
					PH_ZH1: begin
						if (dg) begin
							zh_d    = 7'(acc10({7'd0, zh_q}, d));
							phase_d = PH_ZHH;
						end else failed_d = 1'b1;
					end
					PH_ZHH: begin
						if (ch == CH_COLON) phase_d = PH_ZMF;
						else if (dg) begin
							zm_d    = {3'd0, d};
							phase_d = PH_ZMS;
						end else failed_d = 1'b1;
					end
					PH_ZMF: begin
						if (dg) begin
							zm_d    = {3'd0, d};
							phase_d = PH_ZMS;
						end else failed_d = 1'b1;
					end
					PH_ZMS: begin
						if (dg) begin
							zm_d    = 7'(acc10({7'd0, zm_q}, d));
							phase_d = PH_ZEND;
						end else failed_d = 1'b1;
					end
					default: failed_d = 1'b1;
				endcase
				// Zone suffix, reached from the date, the seconds or the fraction.
				if (zs) begin
					if (ch == CH_UP_Z || ch == CH_LO_Z) begin
						zseen_d = 1'b1;
						zz_d    = 1'b1;
						phase_d = PH_ZZ;
					end else if (ch == CH_PLUS || ch == CH_DASH) begin
						zseen_d = 1'b1;
						zneg_d  = (ch == CH_DASH);
						phase_d = PH_ZSIGN;
					end else failed_d = 1'b1;
				end
			end
		end
	end

	always_comb begin
		ok = !failed_d && (phase_d inside {PH_DATE, PH_SEC, PH_FRAC, PH_ZHH, PH_ZEND, PH_ZZ});
		signed_zone = zseen_d && !zz_d;
		mag = {13'd0, zh_d} * SECS_PER_HOUR + {13'd0, zm_d} * SECS_PER_MIN;
		res = '0;
		if (ok) begin
			res.valid_res  = 1'b1;
			res.year       = year_d;
			res.month      = month_d;
			res.day        = day_d;
			res.has_time   = timed_d;
			res.hour       = timed_d ? hour_d : 7'd0;
			res.minute     = timed_d ? minute_d : 7'd0;
			res.second     = timed_d ? second_d : 7'd0;
			res.has_zone   = zseen_d;
			res.zone_was_z = zz_d;
			if (signed_zone) res.offset_seconds = zneg_d ? -mag : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			zh_q     <= '0;
			zm_q     <= '0;
			zneg_q   <= 1'b0;
			zseen_q  <= 1'b0;
			zz_q     <= 1'b0;
			failed_q <= 1'b0;
			timed_q  <= 1'b0;
			trail_q  <= 1'b0;
		end else if (step) begin
			if (last) begin
				phase_q  <= PH_LEAD;
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				zh_q     <= '0;
				zm_q     <= '0;
				zneg_q   <= 1'b0;
				zseen_q  <= 1'b0;
				zz_q     <= 1'b0;
				failed_q <= 1'b0;
				timed_q  <= 1'b0;
				trail_q  <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				zh_q     <= zh_d;
				zm_q     <= zm_d;
				zneg_q   <= zneg_d;
				zseen_q  <= zseen_d;
				zz_q     <= zz_d;
				failed_q <= failed_d;
				timed_q  <= timed_d;
				trail_q  <= trail_d;
			end
		end
	end

	`ASSERT_CLK(a_restart_after_last, step && last |=> phase_q == PH_LEAD && !failed_q && !trail_q, "parser did not restart after the final beat")
	`ASSERT_CLK(a_failed_sticky, failed_q && !(step && last) |=> failed_q, "failure cleared before the end of the string")
	`ASSERT_CLK(a_phase_onehot, $onehot(phase_q), "parser phase lost its one-hot code")

endmodule

>>> rtl/core/iso_date_time_parser_top.sv
// Top level of the ISO 8601 date-time parser: stream ports, input stage and result register.
// Depends on idtp_pkg, idtp_fsm and assert_macros.svh.
//
// Channel   Direction  Beat contents
// s_*       in         one text byte in tdata, tlast on the final byte of the string
// m_*       out        one parse result per string, fields in tdata, flags in tuser
//
// Each beat is taken into an input register; from there the parser updates its state and, on a
// final beat, writes the finished result into the output register. A beat can therefore be
// accepted in every cycle while no final beat waits there on a held result, so the sustained
// rate is one byte per cycle, set by the single parser state update per beat.
// Reset clears the parser to its leading-whitespace state and empties both registers at once.
// A result waiting on m_tready holds only a final beat in the input stage; other beats flow on.
`include "assert_macros.svh"

module iso_date_time_parser_top
	import idtp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] ch
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // year, month, day, hour, minute, second, offset_seconds, pad
	output logic [TUSER_W-1:0] m_tuser   // valid_res, has_time, has_zone, zone_was_z
);

	logic       vld_s1, last_s1, adv_s1, step;
	logic [7:0] ch_s1;
	idtp_res_t  res, out_q;
	logic       out_vld_q;

	// A non-final beat never needs the output register, so it always moves on.
	assign adv_s1   = !(vld_s1 && last_s1) || !out_vld_q || m_tready;
	assign s_tready = !vld_s1 || adv_s1;
	assign step     = vld_s1 && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	idtp_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.ch     (ch_s1),
		.last   (last_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (step && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) out_q <= res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'd0, out_q.offset_seconds, out_q.second, out_q.minute, out_q.hour,
		out_q.day, out_q.month, out_q.year};
	assign m_tuser  = {out_q.zone_was_z, out_q.has_zone, out_q.has_time, out_q.valid_res};

	`ASSERT_CLK(a_result_from_last, $rose(m_tvalid) |-> $past(step && last_s1), "result appeared without a final beat")
	`ASSERT_CLK(a_stall_only_on_last, vld_s1 && !adv_s1 |-> last_s1 && m_tvalid && !m_tready, "input stage stalled without a blocked result")
	`ASSERT_CLK(a_invalid_is_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tuser == '0, "failed result carries non-zero fields")
	`ASSERT_CLK(a_offset_needs_sign, m_tvalid && !(m_tuser[2] && !m_tuser[3]) |-> m_tdata[68:49] == '0, "offset set without a signed zone")

endmodule

>>> verif/tb_iso_date_time_parser_top.sv
// Self-checking testbench for iso_date_time_parser_top: text strings go in as byte beats and
// each parse result is compared with a behavioural model kept in step with the accepted beats.
// Depends on idtp_pkg and the parser RTL; it needs no other file.
`timescale 1ns / 1ps

module tb_iso_date_time_parser_top;
	import idtp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int STALL_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;      // [7:0] ch
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_W-1:0] m_tdata;  // year, month, day, hour, minute, second, offset_seconds, pad
	logic [TUSER_W-1:0] m_tuser;  // valid_res, has_time, has_zone, zone_was_z

	// Idling controls for the two sides, and the long hold-off of the result side.
	logic tx_gaps = 1'b1;
	logic rx_gaps = 1'b1;
	logic m_hold = 1'b0;
	event hold_start;

	int beats_taken = 0;
	int mismatches = 0;
	int cycles = 0;

	// Parse results still owed by the block, oldest first.
	idtp_res_t pending_results[$];

	// Parser model state.
	idtp_phase_t p_phase;
	logic [13:0] p_year;
	logic [6:0] p_month, p_day, p_hour, p_min, p_sec, p_zhour, p_zmin;
	logic p_zneg, p_zseen, p_zz, p_fail, p_timed, p_trail;

	iso_date_time_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A run that hangs is ended here rather than left to spin.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// The result side: ready changes only at the falling edge. It idles now and then when gaps
	// are enabled, and is held low throughout a hold-off.
	always @(negedge clk) begin
		m_tready = !m_hold && !(rx_gaps && ($urandom_range(0, 99) < 9));
	end

	// The hold-off is timed here, in its own process, so that the sender can keep offering
	// beats while the result side refuses them.
	initial begin
		forever begin
			@(hold_start);
			m_hold = 1'b1;
			repeat (STALL_CYCLES) @(posedge clk);
			m_hold = 1'b0;
		end
	end

	task automatic clear_parser_model();
		p_phase = PH_LEAD;
		p_year = '0;
		{p_month, p_day, p_hour, p_min, p_sec, p_zhour, p_zmin} = '0;
		{p_zneg, p_zseen, p_zz, p_fail, p_timed, p_trail} = '0;
	endtask

	// Start of a zone suffix, reached from the date-only, whole-second and fraction positions.
	task automatic open_zone(input logic [7:0] c);
		if (c == CH_UP_Z || c == CH_LO_Z) begin
			p_zseen = 1'b1;
			p_zz = 1'b1;
			p_phase = PH_ZZ;
		end else if (c == CH_PLUS || c == CH_DASH) begin
			p_zseen = 1'b1;
			p_zneg = (c == CH_DASH);
			p_phase = PH_ZSIGN;
		end else begin
			p_fail = 1'b1;
		end
	endtask

	// Advances the model by one accepted beat; a final beat yields the expected result, after
	// which the model starts afresh for the next string.
	task automatic parse_byte(input logic [7:0] c, input logic fin);
		logic space, dig;
		logic [3:0] d;
		logic [19:0] mag;
		idtp_phase_t fwd;
		idtp_res_t r;
		space = c inside {CH_SPACE, [CH_TAB:CH_CR]};
		dig = c inside {[CH_ZERO:CH_NINE]};
		d = 4'(c - CH_ZERO);
		fwd = idtp_phase_t'(p_phase << 1);
		if (!p_fail) begin
			if (space) begin
				if (p_phase != PH_LEAD)
					p_trail = 1'b1;
			end else if (p_trail) begin
				// Anything but whitespace once the trailing whitespace has begun.
				p_fail = 1'b1;
			end else if (p_phase == PH_LEAD && !dig) begin
				p_fail = 1'b1;
			end else if (p_phase inside {PH_LEAD, PH_Y1, PH_Y2, PH_Y3}) begin
				if (dig) begin
					p_year = 14'(p_year * 10 + d);
					p_phase = fwd;
				end else begin
					p_fail = 1'b1;
				end
			end else begin
				case (p_phase)
					PH_DASH1, PH_DASH2: begin
						if (c == CH_DASH) p_phase = fwd;
						else p_fail = 1'b1;
					end
					PH_C1, PH_C2: begin
						if (c == CH_COLON) p_phase = fwd;
						else p_fail = 1'b1;
					end
					PH_MO0, PH_MO1: begin
						if (dig) begin
							p_month = 7'(p_month * 10 + d);
							p_phase = fwd;
						end else p_fail = 1'b1;
					end
					PH_DA0, PH_DA1: begin
						if (dig) begin
							p_day = 7'(p_day * 10 + d);
							p_phase = fwd;
						end else p_fail = 1'b1;
					end
					PH_DATE: begin
						if (c == CH_UP_T) p_phase = PH_H0;
						else open_zone(c);
					end
					PH_H0, PH_H1: begin
						if (dig) begin
							p_hour = 7'(p_hour * 10 + d);
							p_phase = fwd;
						end else p_fail = 1'b1;
					end
					PH_MI0, PH_MI1: begin
						if (dig) begin
							p_min = 7'(p_min * 10 + d);
							p_phase = fwd;
						end else p_fail = 1'b1;
					end
					PH_S0, PH_S1: begin
						if (dig) begin
							p_sec = 7'(p_sec * 10 + d);
							p_phase = fwd;
							if (fwd == PH_SEC)
								p_timed = 1'b1;
						end else p_fail = 1'b1;
					end
					PH_SEC: begin
						if (c == CH_DOT) p_phase = PH_FRAC;
						else open_zone(c);
					end
					PH_FRAC: begin
						// Fraction digits are swallowed without being kept.
						if (!dig) open_zone(c);
					end
					PH_ZSIGN: begin
						if (dig) begin
							p_zhour = {3'd0, d};
							p_phase = PH_ZH1;
						end else p_fail = 1'b1;
					end
					PH_ZH1: begin
						if (dig) begin
							p_zhour = 7'(p_zhour * 10 + d);
							p_phase = PH_ZHH;
						end else p_fail = 1'b1;
					end
					PH_ZHH: begin
						if (c == CH_COLON) begin
							p_phase = PH_ZMF;
						end else if (dig) begin
							p_zmin = {3'd0, d};
							p_phase = PH_ZMS;
						end else p_fail = 1'b1;
					end
					PH_ZMF: begin
						if (dig) begin
							p_zmin = {3'd0, d};
							p_phase = PH_ZMS;
						end else p_fail = 1'b1;
					end
					PH_ZMS: begin
						if (dig) begin
							p_zmin = 7'(p_zmin * 10 + d);
							p_phase = PH_ZEND;
						end else p_fail = 1'b1;
					end
					default: p_fail = 1'b1;
				endcase
			end
		end
		if (fin) begin
			r = '0;
			if (!p_fail && p_phase inside {PH_DATE, PH_SEC, PH_FRAC, PH_ZHH, PH_ZEND, PH_ZZ}) begin
				r.valid_res = 1'b1;
				r.year = p_year;
				r.month = p_month;
				r.day = p_day;
				r.has_time = p_timed;
				if (p_timed) begin
					r.hour = p_hour;
					r.minute = p_min;
					r.second = p_sec;
				end
				r.has_zone = p_zseen;
				r.zone_was_z = p_zz;
				mag = {13'd0, p_zhour} * SECS_PER_HOUR + {13'd0, p_zmin} * SECS_PER_MIN;
				if (p_zseen && !p_zz)
					r.offset_seconds = p_zneg ? -mag : mag;
			end
			pending_results.push_back(r);
			clear_parser_model();
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Every result beat is taken apart and compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		idtp_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.year = m_tdata[13:0];
			got.month = m_tdata[20:14];
			got.day = m_tdata[27:21];
			got.hour = m_tdata[34:28];
			got.minute = m_tdata[41:35];
			got.second = m_tdata[48:42];
			got.offset_seconds = m_tdata[68:49];
			got.valid_res = m_tuser[0];
			got.has_time = m_tuser[1];
			got.has_zone = m_tuser[2];
			got.zone_was_z = m_tuser[3];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat arrived with none outstanding", $time);
			end else begin
				want = pending_results.pop_front();
				check_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
				check_field("year", 32'(want.year), 32'(got.year));
				check_field("month", 32'(want.month), 32'(got.month));
				check_field("day", 32'(want.day), 32'(got.day));
				check_field("has_time", 32'(want.has_time), 32'(got.has_time));
				check_field("hour", 32'(want.hour), 32'(got.hour));
				check_field("minute", 32'(want.minute), 32'(got.minute));
				check_field("second", 32'(want.second), 32'(got.second));
				check_field("has_zone", 32'(want.has_zone), 32'(got.has_zone));
				check_field("zone_was_z", 32'(want.zone_was_z), 32'(got.zone_was_z));
				check_field("offset_seconds", 32'(want.offset_seconds),
					32'(got.offset_seconds));
			end
		end
	end

	// Offers one byte, entering and leaving at a falling edge. Valid is lowered only for a gap,
	// so back-to-back beats keep it high without a glitch.
	task automatic send_beat(input logic [7:0] c, input logic fin);
		while (tx_gaps && ($urandom_range(0, 99) < 9)) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = c;
		s_tlast = fin;
		do @(posedge clk); while (!s_tready);
		beats_taken++;
		parse_byte(c, fin);
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] txt[$]);
		foreach (txt[i])
			send_beat(txt[i], i == txt.size() - 1);
	endtask

	task automatic send_str(input string s);
		logic [7:0] q[$];
		foreach (s[i])
			q.push_back(s[i]);
		send_text(q);
	endtask

	// Stops offering and waits until every owed result has been taken.
	task automatic drain_results();
		s_tvalid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_space();
		int k;
		k = $urandom_range(8, 13);
		return (k == 8) ? CH_SPACE : 8'(k);
	endfunction

	// Builds one string. Most are well formed with random digits and optional parts; some are
	// damaged by one edit, and a few are plain noise bytes.
	task automatic make_text(output logic [7:0] txt[$]);
		logic [7:0] q[$];
		int kind, pos, zkind;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 10))
				q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) q.push_back(rand_space());
			repeat (4) q.push_back(rand_digit());
			q.push_back(CH_DASH);
			repeat (2) q.push_back(rand_digit());
			q.push_back(CH_DASH);
			repeat (2) q.push_back(rand_digit());
			if ($urandom_range(0, 2) != 0) begin
				q.push_back(CH_UP_T);
				repeat (2) q.push_back(rand_digit());
				q.push_back(CH_COLON);
				repeat (2) q.push_back(rand_digit());
				q.push_back(CH_COLON);
				repeat (2) q.push_back(rand_digit());
				if ($urandom_range(0, 2) == 0) begin
					q.push_back(CH_DOT);
					repeat ($urandom_range(0, 4)) q.push_back(rand_digit());
				end
			end
			zkind = $urandom_range(0, 5);
			case (zkind)
				1: q.push_back(CH_UP_Z);
				2: q.push_back(CH_LO_Z);
				3, 4, 5: begin
					q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
					repeat (2) q.push_back(rand_digit());
					if (zkind == 5) q.push_back(CH_COLON);
					if (zkind != 3) repeat (2) q.push_back(rand_digit());
				end
				default: ;
			endcase
			repeat ($urandom_range(0, 2)) q.push_back(rand_space());
			if (kind >= 75) begin
				pos = $urandom_range(0, q.size() - 1);
				case ($urandom_range(0, 3))
					0: q[pos] = 8'($urandom_range(0, 255));
					1: if (q.size() > 1) q.delete(pos);
					2: q.insert(pos, 8'($urandom_range(0, 255)));
					default: while (q.size() > pos + 1) void'(q.pop_back());
				endcase
			end
		end
		txt = q;
	endtask

	// Hand-picked strings: the widest and narrowest values, each form and each corner of the
	// grammar, including the ways a string is rejected.
	task automatic run_directed_strings();
		logic [7:0] raw[$];
		send_str("2024-02-29");
		send_str("9999-99-99T99:99:99.999999+99:99");
		send_str("0000-00-00T00:00:00Z");
		send_str("  \t1970-01-01T00:00:00z \r\n");
		send_str("2001-12-31T23:59:59-0530");
		send_str("2001-12-31+07");
		send_str("2001-12-31T10:20:30.");
		send_str("2001-12-31.5");
		send_str("2001-12-31t10:20:30");
		send_str("2001-12-31T10:20:30+05:3");
		send_str("2001-12-31T10:20:30+053");
		send_str("2001 -12-31");
		send_str("2001-12-31 Z");
		send_str(" ");
		send_str("\t\n\v\f\r ");
		send_str("x2001-12-31");
		send_str("2001-1");
		send_str("2001-12-31T10:20");
		send_str("2001-12-31T10:20:30.123-00:00");
		send_str("2001-12-31ZZ");
		send_str("12345-01-01");
		raw = '{8'h00, 8'hFF};
		send_text(raw);
		raw = '{8'h7F, 8'h80};
		send_text(raw);
	endtask

	// A stretch in which neither side ever idles.
	task automatic run_unbroken_stream();
		logic [7:0] txt[$];
		int start;
		start = beats_taken;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		while (beats_taken - start < 150) begin
			make_text(txt);
			send_text(txt);
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// The result side holds off for a long stretch while single-byte strings keep coming, so
	// the block fills up and has to refuse beats until the stall ends.
	task automatic run_output_stall();
		-> hold_start;
		repeat (40) begin
			if ($urandom_range(0, 1)) send_str(" ");
			else send_str("Z");
		end
		drain_results();
	endtask

	// The sender stops until every result has come back, then carries on.
	task automatic run_drain_pause();
		logic [7:0] txt[$];
		repeat (3) begin
			make_text(txt);
			send_text(txt);
		end
		drain_results();
		repeat (3) begin
			make_text(txt);
			send_text(txt);
		end
	endtask

	task automatic run_random_strings();
		logic [7:0] txt[$];
		int start, strings;
		start = beats_taken;
		strings = 0;
		while (beats_taken - start < 240 || strings < 10) begin
			make_text(txt);
			send_text(txt);
			strings++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		clear_parser_model();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed_strings();
		run_unbroken_stream();
		run_output_stall();
		run_drain_pause();
		run_random_strings();

		// Let the last results out, then wait on for any stray result beat.
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
